### hw/rtl/ansi_escape_stripper_unit_macros.svh
// Assertion helpers shared by the stripper RTL.
// Each expects clk and rst_n in the enclosing module.
`ifndef ANSI_ESCAPE_STRIPPER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_STRIPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AES_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define AES_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/aes_pkg.sv
`default_nettype none

package aes_pkg;

    // Default bound on CSI parameter bytes scanned for the repeat count
    localparam int unsigned MAX_PARAM_BYTES = 32;

    // Repeat count saturation and field width
    localparam int unsigned MAX_REPEAT = 1024;
    localparam int unsigned REPEAT_W   = 11;
    localparam int unsigned CHAR_W     = 8;

    // Input beat: one raw terminal byte
    typedef struct packed {
        logic [CHAR_W-1:0] in_byte;
        logic              call_start;
    } in_beat_t;

    // Output beat: one character and how many times to emit it
    typedef struct packed {
        logic [CHAR_W-1:0]   out_char;
        logic [REPEAT_W-1:0] repeat_count;
    } out_beat_t;

    // Result handed from the parser to the output buffer
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/aes_parser.sv
`default_nettype none
`include "ansi_escape_stripper_unit_macros.svh"

module aes_parser
    import aes_pkg::*;
#(
    parameter int unsigned P_MAX_PARAM_BYTES = MAX_PARAM_BYTES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_beat_t beat,
    output res_t          res
);

    localparam int unsigned CNT_W  = $clog2(P_MAX_PARAM_BYTES + 1);
    localparam int unsigned PROD_W = REPEAT_W + 4;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BEL    = 8'h07;
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] FINAL_LO  = 8'h40;
    localparam logic [CHAR_W-1:0] FINAL_HI  = 8'h7E;
    localparam logic [CHAR_W-1:0] FIN_CUF   = 8'h43;
    localparam logic [CHAR_W-1:0] FIN_HPR   = 8'h61;
    localparam logic [CHAR_W-1:0] FIN_CUP   = 8'h48;
    localparam logic [CHAR_W-1:0] FIN_HVP   = 8'h66;
    localparam logic [CHAR_W-1:0] FIN_CUU   = 8'h41;
    localparam logic [CHAR_W-1:0] FIN_ED    = 8'h4A;

    typedef enum logic [5:0] {
        ST_NORMAL  = 6'b000001,
        ST_CR      = 6'b000010,
        ST_ESC     = 6'b000100,
        ST_CSI     = 6'b001000,
        ST_OSC     = 6'b010000,
        ST_OSC_ESC = 6'b100000
    } pstate_t;

    typedef enum logic [3:0] {
        PH_WS     = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    pstate_t             state_reg,   state_next;
    phase_t              phase_reg,   phase_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [REPEAT_W-1:0] val_reg,     val_next;
    logic                neg_reg,     neg_next;
    logic                emitted_reg, emitted_next;
    logic                lnl_reg,     lnl_next;

    logic [CHAR_W-1:0]   c;
    logic                emitted_eff;
    logic                lnl_eff;
    pstate_t             norm_state;
    logic                norm_emit;
    logic                is_ws;
    logic                is_sign;
    logic                is_digit;
    logic                is_final;
    logic [PROD_W-1:0]   val_ext;
    logic [PROD_W-1:0]   prod;
    logic [REPEAT_W-1:0] val_sat;
    logic [REPEAT_W-1:0] rep_n;
    logic                emit;
    logic [CHAR_W-1:0]   emit_char;
    logic [REPEAT_W-1:0] emit_cnt;

    // Classify the byte and prepare the digit accumulation
    always_comb
    begin
        c           = beat.in_byte;
        emitted_eff = emitted_reg & ~beat.call_start;
        lnl_eff     = lnl_reg & ~beat.call_start;

        if (c == CH_ESC)
        begin
            norm_state = ST_ESC;
        end
        else if (c == CH_CR)
        begin
            norm_state = ST_CR;
        end
        else
        begin
            norm_state = ST_NORMAL;
        end
        norm_emit = (c >= CH_SPACE) || (c == CH_LF) || (c == CH_TAB);

        is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_final = (c >= FINAL_LO) && (c <= FINAL_HI);

        // value * 10 + digit, saturated
        val_ext = PROD_W'(val_reg);
        prod    = (val_ext << 3) + (val_ext << 1) + PROD_W'(c[3:0]);
        if (prod > PROD_W'(MAX_REPEAT))
        begin
            val_sat = REPEAT_W'(MAX_REPEAT);
        end
        else
        begin
            val_sat = prod[REPEAT_W-1:0];
        end

        // Zero, negative or missing number gives a count of one
        if (((phase_reg == PH_DIGITS) || (phase_reg == PH_DONE)) && !neg_reg
            && (val_reg != '0))
        begin
            rep_n = val_reg;
        end
        else
        begin
            rep_n = REPEAT_W'(1);
        end
    end

    // Advance the parser for one byte
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        neg_next   = neg_reg;
        emit       = 1'b0;
        emit_char  = c;
        emit_cnt   = REPEAT_W'(1);

        case (state_reg)
            ST_ESC:
            begin
                if (c == CH_LBRACK)
                begin
                    state_next = ST_CSI;
                    phase_next = PH_WS;
                    cnt_next   = '0;
                    val_next   = '0;
                    neg_next   = 1'b0;
                end
                else if (c == CH_RBRACK)
                begin
                    state_next = ST_OSC;
                end
                else
                begin
                    state_next = ST_NORMAL;
                end
            end
            ST_CSI:
            begin
                if (!is_final)
                begin
                    // Parameter byte: scan as a decimal number up to the byte limit
                    if (cnt_reg < CNT_W'(P_MAX_PARAM_BYTES))
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if ((phase_reg == PH_WS) && is_ws)
                        begin
                            phase_next = PH_WS;
                        end
                        else if ((phase_reg == PH_WS) && is_sign)
                        begin
                            neg_next   = (c == CH_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (phase_reg == PH_DONE)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (!is_digit)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            val_next   = val_sat;
                        end
                    end
                end
                else
                begin
                    // Final byte: close the sequence and clear the number
                    state_next = ST_NORMAL;
                    phase_next = PH_WS;
                    cnt_next   = '0;
                    val_next   = '0;
                    neg_next   = 1'b0;
                    if ((c == FIN_CUF) || (c == FIN_HPR))
                    begin
                        emit      = 1'b1;
                        emit_char = CH_SPACE;
                        emit_cnt  = rep_n;
                    end
                    else if ((c == FIN_CUP) || (c == FIN_HVP) || (c == FIN_CUU)
                             || (c == FIN_ED))
                    begin
                        emit      = emitted_eff && !lnl_eff;
                        emit_char = CH_LF;
                    end
                end
            end
            ST_OSC:
            begin
                if (c == CH_BEL)
                begin
                    state_next = ST_NORMAL;
                end
                else if (c == CH_ESC)
                begin
                    state_next = ST_OSC_ESC;
                end
            end
            ST_OSC_ESC:
            begin
                state_next = (c == CH_BSLASH) ? ST_NORMAL : ST_OSC;
            end
            default:
            begin
                // Normal and after CR: a CR LF pair yields the LF here as a plain LF
                state_next = norm_state;
                emit       = norm_emit;
            end
        endcase

        if (emit)
        begin
            emitted_next = 1'b1;
            lnl_next     = (emit_char == CH_LF);
        end
        else
        begin
            emitted_next = emitted_eff;
            lnl_next     = lnl_eff;
        end
    end

    // Hold state between beats, update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_NORMAL;
            phase_reg   <= PH_WS;
            cnt_reg     <= '0;
            val_reg     <= '0;
            neg_reg     <= 1'b0;
            emitted_reg <= 1'b0;
            lnl_reg     <= 1'b0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            val_reg     <= val_next;
            neg_reg     <= neg_next;
            emitted_reg <= emitted_next;
            lnl_reg     <= lnl_next;
        end
    end

    assign res.valid             = fire & emit;
    assign res.beat.out_char     = emit_char;
    assign res.beat.repeat_count = emit_cnt;

    `AES_CHECK_NOW(a_count_nonzero, res.valid, res.beat.repeat_count != '0, "zero repeat count")
    `AES_CHECK_NOW(a_repeat_is_space, res.valid && (res.beat.repeat_count != REPEAT_W'(1)), res.beat.out_char == CH_SPACE, "repeat on non-space")
    `AES_CHECK_NOW(a_param_bound, 1'b1, cnt_reg <= CNT_W'(P_MAX_PARAM_BYTES), "param count overrun")
    `AES_CHECK_NOW(a_newline_implies_content, lnl_reg, emitted_reg, "newline flag without content")

endmodule

`default_nettype wire

### hw/rtl/aes_out_buf.sv
`default_nettype none
`include "ansi_escape_stripper_unit_macros.svh"

module aes_out_buf
    import aes_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire res_t res,
    output logic      full,
    output logic      valid,
    input  wire logic stall,
    output out_beat_t data
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_beat_t out_reg;
    out_beat_t skid_reg;
    logic      pop;

    assign pop = out_valid_reg && !stall;

    // Track occupancy of output and skid stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Move payload: skid drains first, otherwise new result lands in the free stage
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res.valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res.beat;
            end
            else
            begin
                out_reg <= res.beat;
            end
        end
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_reg;

    `AES_CHECK_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid filled with output empty")
    `AES_CHECK_NOW(a_no_result_when_full, skid_valid_reg, !res.valid, "result while skid full")
    `AES_CHECK_NEXT(a_skid_drains_to_out, skid_valid_reg && !stall, out_valid_reg && !skid_valid_reg, "skid did not drain")

endmodule

`default_nettype wire

### hw/rtl/ansi_escape_stripper_unit.sv
// ANSI escape stripper: cleans a terminal byte stream.
// Input channel byte_*: one raw byte per beat plus call_start, which marks the
// first byte of a new chunk and clears line-content tracking.
// Output channel char_*: zero or one beat per input byte, a character and a
// repeat count (a space with count for cursor-forward CSI, otherwise 1).
// A result is registered into the output register when its beat is accepted,
// or into the skid stage while a stall holds it. Throughput: one input byte per
// cycle while byte_stall is low; the parser state is a single register stage
// updated by short logic on every accepted beat. Bytes that yield no result
// (escapes, OSC strings, control bytes) are consumed at the same rate.
// Stall: the output register plus a one-entry skid stage absorb a stalled
// receiver; byte_stall rises only once the skid stage holds a result, and
// drops in the cycle after the receiver takes a beat.
// Reset: asynchronous, active low; the parser returns to normal text, the
// number scanner clears, and both output stages empty. No clearing pass.
`default_nettype none

module ansi_escape_stripper_unit
    import aes_pkg::*;
#(
    parameter int unsigned P_MAX_PARAM_BYTES = MAX_PARAM_BYTES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_beat_t  byte_data,
    output logic           char_valid,
    input  wire logic      char_stall,
    output out_beat_t      char_data
);

    logic fire;
    logic full;
    res_t res;

    // Accept a byte whenever the skid stage is free
    assign byte_stall = full;
    assign fire       = byte_valid && !full;

    aes_parser #(
        .P_MAX_PARAM_BYTES(P_MAX_PARAM_BYTES)
    ) u_parser (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (fire),
        .beat (byte_data),
        .res  (res)
    );

    aes_out_buf u_out_buf (
        .clk  (clk),
        .rst_n(rst_n),
        .res  (res),
        .full (full),
        .valid(char_valid),
        .stall(char_stall),
        .data (char_data)
    );

endmodule

`default_nettype wire

### tb/ansi_escape_stripper_checker.sv
`timescale 1ns / 100ps

// Byte codes shared by the stripper checker and the stimulus
package aes_tb_pkg;

    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_HT       = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    // CSI final byte range and the finals that yield a result
    localparam logic [7:0] FIN_LO      = 8'h40;
    localparam logic [7:0] FIN_HI      = 8'h7E;
    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_FWD     = 8'h43;
    localparam logic [7:0] FIN_HOME    = 8'h48;
    localparam logic [7:0] FIN_ERASE   = 8'h4A;
    localparam logic [7:0] FIN_FWD_ALT = 8'h61;
    localparam logic [7:0] FIN_HVP     = 8'h66;

endpackage

module ansi_escape_stripper_checker
    import aes_pkg::*;
    import aes_tb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    input  logic      byte_stall,
    input  in_beat_t  byte_data,
    input  logic      char_valid,
    input  logic      char_stall,
    input  out_beat_t char_data,
    output int        fail_cnt,
    output int        pending_cnt
);

    typedef enum logic [2:0]
    {
        PS_TEXT,
        PS_CR,
        PS_ESC,
        PS_CSI,
        PS_OSC,
        PS_OSC_ESC
    } parse_e;

    typedef enum logic [1:0]
    {
        NP_WS,
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } num_phase_e;

    // Shadow of the parser and the repeat-count scanner
    parse_e      parse_st;
    num_phase_e  num_ph;
    int unsigned parm_cnt;
    int unsigned num_val;
    bit          num_neg;
    bit          line_used;
    bit          at_newline;

    // Character beats still owed by the block, oldest first
    out_beat_t   owed_chars[$];

    function automatic void clear_number();
        parm_cnt = 0;
        num_ph   = NP_WS;
        num_val  = 0;
        num_neg  = 1'b0;
    endfunction

    // Queue one owed beat and track line content for this call
    function automatic void owe_char(logic [7:0] ch, int unsigned cnt);
        out_beat_t r;
        r.out_char     = ch;
        r.repeat_count = REPEAT_W'(cnt);
        owed_chars     = {owed_chars, r};
        line_used  = 1'b1;
        at_newline = (ch == CH_LF);
    endfunction

    // Handle a byte as plain text
    function automatic void text_byte(logic [7:0] c);
        if (c == CH_ESC)
            parse_st = PS_ESC;
        else if (c == CH_CR)
            parse_st = PS_CR;
        else if (c >= CH_SPACE || c == CH_LF || c == CH_HT)
            owe_char(c, 1);
    endfunction

    // Read one CSI parameter byte the way a decimal parse would
    function automatic void scan_param(logic [7:0] c);
        if (parm_cnt >= MAX_PARAM_BYTES)
            return;
        parm_cnt++;
        if (num_ph == NP_WS)
        begin
            if (c == CH_SPACE || (c >= CH_HT && c <= CH_CR))
                return;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                num_neg = (c == CH_MINUS);
                num_ph  = NP_SIGN;
                return;
            end
        end
        if (num_ph == NP_DONE)
            return;
        if (c < CH_ZERO || c > CH_NINE)
        begin
            num_ph = NP_DONE;
            return;
        end
        num_ph  = NP_DIGITS;
        num_val = num_val * 10 + (c - CH_ZERO);
        if (num_val > MAX_REPEAT)
            num_val = MAX_REPEAT;
    endfunction

    // Advance the shadow parser by one accepted byte beat
    function automatic void strip_byte(in_beat_t b);
        logic [7:0]  c;
        int unsigned cnt;
        c = b.in_byte;
        if (b.call_start)
        begin
            line_used  = 1'b0;
            at_newline = 1'b0;
        end
        case (parse_st)
            PS_CR:
            begin
                parse_st = PS_TEXT;
                if (c == CH_LF)
                    owe_char(CH_LF, 1);
                else
                    text_byte(c);
            end
            PS_ESC:
            begin
                if (c == CH_LBRACKET)
                begin
                    clear_number();
                    parse_st = PS_CSI;
                end
                else if (c == CH_RBRACKET)
                    parse_st = PS_OSC;
                else
                    parse_st = PS_TEXT;
            end
            PS_CSI:
            begin
                if (c < FIN_LO || c > FIN_HI)
                    scan_param(c);
                else
                begin
                    cnt = (num_ph >= NP_DIGITS && !num_neg && num_val > 0) ? num_val : 1;
                    parse_st = PS_TEXT;
                    clear_number();
                    if (c == FIN_FWD || c == FIN_FWD_ALT)
                        owe_char(CH_SPACE, cnt);
                    else if ((c == FIN_HOME || c == FIN_HVP || c == FIN_UP || c == FIN_ERASE)
                             && line_used && !at_newline)
                        owe_char(CH_LF, 1);
                end
            end
            PS_OSC:
            begin
                if (c == CH_BEL)
                    parse_st = PS_TEXT;
                else if (c == CH_ESC)
                    parse_st = PS_OSC_ESC;
            end
            PS_OSC_ESC:
                parse_st = (c == CH_BSLASH) ? PS_TEXT : PS_OSC;
            default:
            begin
                parse_st = PS_TEXT;
                text_byte(c);
            end
        endcase
    endfunction

    // Predict on byte beats, compare on character beats
    always @(posedge clk)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            parse_st   = PS_TEXT;
            clear_number();
            line_used  = 1'b0;
            at_newline = 1'b0;
            owed_chars.delete();
            fail_cnt   = 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                strip_byte(byte_data);
            if (char_valid && !char_stall)
            begin
                if (owed_chars.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected char beat: expected none, %s %02h count %0d",
                             $time, "got char", char_data.out_char,
                             char_data.repeat_count);
                end
                else
                begin
                    want = owed_chars.pop_front();
                    if (char_data.out_char != want.out_char
                        || char_data.repeat_count != want.repeat_count)
                    begin
                        fail_cnt++;
                        $display("%0t: char beat mismatch: expected char %02h count %0d,",
                                 $time, want.out_char, want.repeat_count,
                                 " got char %02h count %0d",
                                 char_data.out_char, char_data.repeat_count);
                    end
                end
            end
        end
        pending_cnt = owed_chars.size();
    end

endmodule

### tb/tb_ansi_escape_stripper_unit.sv
`timescale 1ns / 100ps

module tb_ansi_escape_stripper_unit;

    import aes_pkg::*;
    import aes_tb_pkg::*;

    localparam int unsigned PHASE_BYTES = 340;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned FLOOD_BYTES = 24;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    in_beat_t    byte_data;
    logic        char_valid;
    logic        char_stall;
    out_beat_t   char_data;

    int          fail_cnt;
    int          pending_cnt;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_requests;
    int unsigned bytes_sent;

    ansi_escape_stripper_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    ansi_escape_stripper_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_data   (char_data),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Abort a hung run
    initial
    begin
        #2_000_000;
        $display("ansi_escape_stripper_unit test failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int unsigned held;
        int unsigned hold_served;
        held        = 0;
        hold_served = 0;
        char_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                char_stall <= 1'b1;
                held++;
                if (held == HOLD_CYCLES)
                begin
                    held = 0;
                    hold_served++;
                end
            end
            else
                char_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Offer one byte beat after a random gap and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic cs);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid           <= 1'b1;
        byte_data.in_byte    <= b;
        byte_data.call_start <= cs;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send a byte that starts a new chunk now and then
    task automatic send_text(input logic [7:0] b);
        send_beat(b, $urandom_range(9) == 0);
    endtask

    // Stop offering and wait until every owed beat has come back
    task automatic wait_idle();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_cnt != 0);
        repeat (4) @(posedge clk);
    endtask

    // CSI with a shaped parameter field and a random final
    task automatic send_csi();
        int unsigned n_ws;
        int unsigned n_dig;
        int unsigned n_tail;
        int unsigned i;
        send_text(CH_ESC);
        send_text(CH_LBRACKET);
        // mostly short fields; a few long enough to hit the byte cap
        n_ws = ($urandom_range(7) == 0) ? $urandom_range(34, 26) : $urandom_range(2);
        for (i = 0; i < n_ws; i++)
            send_text($urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_HT)));
        case ($urandom_range(3))
            0: send_text(CH_PLUS);
            1: send_text(CH_MINUS);
            default: ;
        endcase
        n_dig = $urandom_range(5);
        for (i = 0; i < n_dig; i++)
            send_text(8'($urandom_range(CH_NINE, CH_ZERO)));
        // trailing parameters, separators or junk that is never a final
        n_tail = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
        for (i = 0; i < n_tail; i++)
        begin
            if (i == 0 && $urandom_range(1))
                send_text(CH_SEMI);
            else if ($urandom_range(1))
                send_text(8'($urandom_range(8'h3F)));
            else
                send_text(8'($urandom_range(8'hFF, 8'h7F)));
        end
        case ($urandom_range(7))
            0: send_text(FIN_FWD);
            1: send_text(FIN_FWD_ALT);
            2: send_text(FIN_HOME);
            3: send_text(FIN_HVP);
            4: send_text(FIN_UP);
            5: send_text(FIN_ERASE);
            default: send_text(8'($urandom_range(FIN_HI, FIN_LO)));
        endcase
    endtask

    // OSC string with random body, stray escapes and either terminator
    task automatic send_osc();
        int unsigned len;
        int unsigned i;
        logic [7:0]  c;
        send_text(CH_ESC);
        send_text(CH_RBRACKET);
        len = $urandom_range(8);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(6) == 0)
            begin
                send_text(CH_ESC);
                do
                    c = 8'($urandom_range(255));
                while (c == CH_BSLASH);
                send_text(c);
            end
            else
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_BEL || c == CH_ESC);
                send_text(c);
            end
        end
        if ($urandom_range(1))
            send_text(CH_BEL);
        else
        begin
            send_text(CH_ESC);
            send_text(CH_BSLASH);
        end
    endtask

    // Pick one random fragment of terminal output
    task automatic send_fragment();
        int unsigned kind;
        int unsigned len;
        int unsigned i;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            len = $urandom_range(6, 1);
            for (i = 0; i < len; i++)
                send_text(8'($urandom_range(8'hFF, CH_SPACE)));
        end
        else if (kind < 40)
        begin
            case ($urandom_range(3))
                0: send_text(CH_LF);
                1: send_text(CH_HT);
                2:
                begin
                    send_text(CH_CR);
                    send_text(CH_LF);
                end
                default:
                begin
                    send_text(CH_CR);
                    send_text(8'($urandom_range(255)));
                end
            endcase
        end
        else if (kind < 70)
            send_csi();
        else if (kind < 80)
            send_osc();
        else if (kind < 85)
        begin
            send_text(CH_ESC);
            send_text(8'($urandom_range(255)));
        end
        else if (kind < 90)
            send_text(8'($urandom_range(8'h1F)));
        else
            send_text(8'($urandom_range(255)));
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [7:0]  directed_bytes[$];
        int unsigned i;
        int unsigned phase;
        int unsigned stop_at;

        rst_n              = 1'b0;
        byte_valid         = 1'b0;
        byte_data          = '0;
        sender_idle_pct    = 17;
        receiver_stall_pct = 50;
        hold_requests      = 0;
        bytes_sent         = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, line endings, control bytes, short escapes, OSC forms
        // and the CSI finals that yield a result
        directed_bytes = '{
            CH_SPACE, 8'hFF, CH_HT, CH_LF, 8'h00, CH_CR, CH_LF, CH_CR, "A",
            CH_ESC, "x", CH_ESC, CH_RBRACKET, "a", CH_BEL,
            CH_ESC, CH_RBRACKET, CH_ESC, CH_ESC, CH_ESC, CH_BSLASH,
            CH_ESC, CH_LBRACKET, "5", FIN_FWD,
            CH_ESC, CH_LBRACKET, FIN_HOME,
            CH_ESC, CH_LBRACKET, FIN_ERASE
        };
        // the erase sequence opens a fresh chunk, so it yields nothing
        for (i = 0; i < directed_bytes.size(); i++)
            send_beat(directed_bytes[i], i == 0 || i == 28);
        wait_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 17;
                    receiver_stall_pct = 50;
                end
                1:
                begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 17;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    // hold the receiver off while text keeps flowing in
                    hold_requests <= hold_requests + 1;
                    for (i = 0; i < FLOOD_BYTES; i++)
                        send_text(8'($urandom_range(8'hFF, CH_SPACE)));
                end
            endcase
            stop_at = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at)
                send_fragment();
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("ansi_escape_stripper_unit test passed");
        else
            $display("ansi_escape_stripper_unit test failed");
        $finish;
    end

endmodule
